>>> rtl/ptq_pkg.sv
// shared types and constants for the updatable priority task queue
// no dependencies; imported by every module of the block except ptq_ram
`default_nettype none

package ptq_pkg;

  localparam int TASK_SLOTS    = 1024;
  localparam int USER_BITS     = 16;
  localparam int PRIORITY_BITS = 30;
  localparam int ID_BITS       = 10;
  localparam int MODE_BITS     = 2;
  localparam int SLOT_BITS     = $clog2(TASK_SLOTS);

  localparam int IN_FIELD_BITS  = USER_BITS + ID_BITS + PRIORITY_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((USER_BITS + 7) / 8) * 8;

  localparam logic [MODE_BITS-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_EDIT   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_EXEC   = 2'd3;

  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_POP    = 2'd3;

  typedef struct packed {
    logic                     valid;
    logic [PRIORITY_BITS-1:0] prio;
    logic [ID_BITS-1:0]       id;
    logic [USER_BITS-1:0]     user;
  } entry_t;

  typedef struct packed {
    logic [1:0]               op;
    logic [PRIORITY_BITS-1:0] prio;
    logic [ID_BITS-1:0]       id;
    logic [USER_BITS-1:0]     user;
  } chain_cmd_t;

  typedef struct packed {
    logic                     live;
    logic [USER_BITS-1:0]     user;
    logic [PRIORITY_BITS-1:0] prio;
  } slot_t;

endpackage

`default_nettype wire

>>> rtl/ptq_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module ptq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/ptq_cell.sv
// one cell of the sorted task chain, highest key nearest the head
// depends on ptq_pkg
`default_nettype none

module ptq_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ptq_pkg::chain_cmd_t cmd,
  input  wire ptq_pkg::entry_t     left,
  input  wire logic                left_ahead,
  input  wire ptq_pkg::entry_t     right,
  output ptq_pkg::entry_t          ent,
  output logic                     ahead
);
  import ptq_pkg::*;

  entry_t ent_next;
  entry_t new_ent;

  // this cell's task ranks above the broadcast key
  assign ahead = ent.valid && ({ent.prio, ent.id} > {cmd.prio, cmd.id});

  always_comb begin
    new_ent.valid = 1'b1;
    new_ent.prio  = cmd.prio;
    new_ent.id    = cmd.id;
    new_ent.user  = cmd.user;
    ent_next      = ent;
    case (cmd.op)
      CMD_INSERT: begin
        if (!ahead) begin
          ent_next = left_ahead ? new_ent : left;
        end
      end
      CMD_DELETE: begin
        if (!ahead) begin
          ent_next = right;
        end
      end
      CMD_POP: begin
        ent_next = right;
      end
      default: begin
        ent_next = ent;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
    ent.prio <= ent_next.prio;
    ent.id   <= ent_next.id;
    ent.user <= ent_next.user;
  end

endmodule

`default_nettype wire

>>> rtl/ptq_chain.sv
// row of ptq_cell instances kept sorted by priority then task id
// depends on ptq_pkg and ptq_cell
`default_nettype none

module ptq_chain (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ptq_pkg::chain_cmd_t cmd,
  output ptq_pkg::entry_t          head
);
  import ptq_pkg::*;

  entry_t                ents   [TASK_SLOTS];
  entry_t                lefts  [TASK_SLOTS];
  entry_t                rights [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] ahead;
  logic [TASK_SLOTS-1:0] left_ahead;

  genvar i;
  generate
    for (i = 0; i < TASK_SLOTS; i++) begin : g_cell
      if (i == 0) begin : g_first
        assign lefts[i]      = '0;
        assign left_ahead[i] = 1'b1;
      end else begin : g_mid
        assign lefts[i]      = ents[i-1];
        assign left_ahead[i] = ahead[i-1];
      end
      if (i == TASK_SLOTS - 1) begin : g_last
        assign rights[i] = '0;
      end else begin : g_inner
        assign rights[i] = ents[i+1];
      end
      ptq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .left       (lefts[i]),
        .left_ahead (left_ahead[i]),
        .right      (rights[i]),
        .ent        (ents[i]),
        .ahead      (ahead[i])
      );
    end
  endgenerate

  assign head = ents[0];

endmodule

`default_nettype wire

>>> rtl/updatable_priority_task_queue.sv
// Updatable priority task queue: add, edit, remove and execute-top on up to
// 1024 tasks.
// Input beat: s_tuser = mode, s_tdata = user_id, task_id, priority_req.
// Output beat (execute-top only): m_tuser = found, m_tdata = exec_user.
// Tasks sit in a chain of cells sorted by priority then task id, so the
// top task is always in the head cell; a slot ram indexed by task id holds
// liveness, user and priority so a task's place in the chain can be found
// by its key. An accepted beat reads the slot ram, then makes one chain
// update; add or edit of a live task makes two (delete, then insert).
// Execute-top results go to the output register in the lookup state, which
// waits while that register holds a stalled result. After reset the slot ram
// is swept clear with s_tready low; chain cells are emptied at reset at once.
// A stalled result holds in the output register; other beats keep being
// taken, and only a following execute-top waits for the register to free.
// depends on ptq_pkg, ptq_chain, ptq_ram
`default_nettype none

module updatable_priority_task_queue (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // user_id, task_id, priority_req
  input  wire logic [ptq_pkg::IN_TDATA_BITS-1:0]   s_tdata,
  // mode
  input  wire logic [ptq_pkg::MODE_BITS-1:0]       s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // exec_user
  output logic      [ptq_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
  // found
  output logic                                     m_tuser
);
  import ptq_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;
  localparam logic [1:0] ST_INS   = 2'd3;

  logic [1:0]               state;
  logic [1:0]               state_next;
  logic [SLOT_BITS-1:0]     clr_addr;
  logic [MODE_BITS-1:0]     op_mode;
  logic [USER_BITS-1:0]     op_user;
  logic [USER_BITS-1:0]     op_user_next;
  logic [ID_BITS-1:0]       op_id;
  logic [PRIORITY_BITS-1:0] op_prio;
  logic                     out_valid;
  logic                     out_valid_next;
  logic                     out_found;
  logic                     out_found_next;
  logic [USER_BITS-1:0]     out_user;
  logic [USER_BITS-1:0]     out_user_next;

  logic                     accept;
  logic                     in_range;
  logic                     ram_we;
  logic [SLOT_BITS-1:0]     ram_waddr;
  slot_t                    ram_wdata;
  slot_t                    ram_rdata;
  chain_cmd_t               cmd;
  entry_t                   head;

  logic [USER_BITS-1:0]     in_user;
  logic [ID_BITS-1:0]       in_id;
  logic [PRIORITY_BITS-1:0] in_prio;

  assign in_user = s_tdata[USER_BITS-1:0];
  assign in_id   = s_tdata[USER_BITS +: ID_BITS];
  assign in_prio = s_tdata[USER_BITS+ID_BITS +: PRIORITY_BITS];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_range = ({1'b0, op_id} < (ID_BITS+1)'(TASK_SLOTS));

  assign m_tvalid = out_valid;
  assign m_tuser  = out_found;
  assign m_tdata  = OUT_TDATA_BITS'(out_user);

  ptq_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (TASK_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_id[SLOT_BITS-1:0]),
    .rdata (ram_rdata)
  );

  ptq_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .head (head)
  );

  always_comb begin
    state_next     = state;
    op_user_next   = op_user;
    out_valid_next = out_valid && !m_tready;
    out_found_next = out_found;
    out_user_next  = out_user;
    ram_we         = 1'b0;
    ram_waddr      = op_id[SLOT_BITS-1:0];
    ram_wdata      = '0;
    cmd.op         = CMD_NONE;
    cmd.prio       = op_prio;
    cmd.id         = op_id;
    cmd.user       = op_user;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        if (clr_addr == SLOT_BITS'(TASK_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_IDLE;
        case (op_mode)
          MODE_EXEC: begin
            if (!out_valid || m_tready) begin
              cmd.op         = CMD_POP;
              out_valid_next = 1'b1;
              out_found_next = head.valid;
              out_user_next  = head.valid ? head.user : '0;
              ram_we         = head.valid;
              ram_waddr      = head.id[SLOT_BITS-1:0];
              ram_wdata      = '0;
            end else begin
              state_next = ST_LOOK;
            end
          end
          MODE_ADD: begin
            if (in_range) begin
              ram_we         = 1'b1;
              ram_wdata.live = 1'b1;
              ram_wdata.user = op_user;
              ram_wdata.prio = op_prio;
              if (ram_rdata.live) begin
                cmd.op     = CMD_DELETE;
                cmd.prio   = ram_rdata.prio;
                state_next = ST_INS;
              end else begin
                cmd.op = CMD_INSERT;
              end
            end
          end
          MODE_EDIT: begin
            if (in_range && ram_rdata.live) begin
              ram_we         = 1'b1;
              ram_wdata.live = 1'b1;
              ram_wdata.user = ram_rdata.user;
              ram_wdata.prio = op_prio;
              cmd.op         = CMD_DELETE;
              cmd.prio       = ram_rdata.prio;
              op_user_next   = ram_rdata.user;
              state_next     = ST_INS;
            end
          end
          MODE_REMOVE: begin
            if (in_range && ram_rdata.live) begin
              ram_we    = 1'b1;
              ram_wdata = '0;
              cmd.op    = CMD_DELETE;
              cmd.prio  = ram_rdata.prio;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_INS: begin
        cmd.op     = CMD_INSERT;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_found <= out_found_next;
    out_user  <= out_user_next;
    if (accept) begin
      op_mode <= s_tuser;
      op_user <= in_user;
      op_id   <= in_id;
      op_prio <= in_prio;
    end else begin
      op_user <= op_user_next;
    end
  end

`ifndef SYNTHESIS
  a_one_beat_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input beat taken while previous beat still in progress");

  a_no_write_when_reading: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !ram_we)
    else $error("slot ram written in the cycle of a lookup");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_LOOK && $past(op_mode) == MODE_EXEC)
    else $error("result beat without an execute-top");

  a_empty_head_not_found: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOOK && op_mode == MODE_EXEC && !head.valid
      && (!out_valid || m_tready) |=> m_tvalid && !m_tuser)
    else $error("execute-top on empty chain did not report not found");
`endif

endmodule

`default_nettype wire

>>> dv/tb_updatable_priority_task_queue.sv
// testbench for updatable_priority_task_queue: directed and random add, edit,
// remove and execute-top beats, with an in-bench task table predicting each result
// depends on rtl/ptq_pkg.sv and rtl/updatable_priority_task_queue.sv
`timescale 1ns / 100ps

module tb_updatable_priority_task_queue;
  import ptq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [PRIORITY_BITS-1:0] PRIO_MAX = '1;
  localparam logic [USER_BITS-1:0] USER_MAX = '1;

  typedef struct {
    logic                 found;
    logic [USER_BITS-1:0] user;
  } exec_result_t;

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [IN_TDATA_BITS-1:0]  s_tdata;
  logic [MODE_BITS-1:0]      s_tuser;
  logic                      m_tvalid;
  logic                      m_tready;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic                      m_tuser;

  // task table as the block should hold it
  bit                       task_live [TASK_SLOTS];
  logic [USER_BITS-1:0]     task_user [TASK_SLOTS];
  logic [PRIORITY_BITS-1:0] task_prio [TASK_SLOTS];

  exec_result_t exec_expected[$];
  int err_count = 0;
  int cycle_count = 0;
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  int rx_long_hold = 0;
  int rx_wait = 0;

  updatable_priority_task_queue DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // apply one operation to the task table, queue the execute-top result
  function automatic void apply_task_op(logic [MODE_BITS-1:0] mode,
                                        logic [USER_BITS-1:0] user,
                                        logic [ID_BITS-1:0] id,
                                        logic [PRIORITY_BITS-1:0] prio);
    exec_result_t res;
    bit any;
    int best;
    logic [PRIORITY_BITS-1:0] best_prio;
    any = 1'b0;
    best = 0;
    best_prio = '0;
    case (mode)
      MODE_ADD: begin
        task_live[id] = 1'b1;
        task_user[id] = user;
        task_prio[id] = prio;
      end
      MODE_EDIT: begin
        if (task_live[id]) task_prio[id] = prio;
      end
      MODE_REMOVE: begin
        task_live[id] = 1'b0;
      end
      default: begin
        // scan from the top id down so a tie keeps the highest id
        for (int s = TASK_SLOTS - 1; s >= 0; s--) begin
          if (task_live[s] && (!any || task_prio[s] > best_prio)) begin
            any = 1'b1;
            best = s;
            best_prio = task_prio[s];
          end
        end
        res.found = any;
        res.user = '0;
        if (any) begin
          task_live[best] = 1'b0;
          res.user = task_user[best];
        end
        exec_expected.push_back(res);
      end
    endcase
  endfunction

  task automatic send_op(logic [MODE_BITS-1:0] mode, logic [USER_BITS-1:0] user,
                         logic [ID_BITS-1:0] id, logic [PRIORITY_BITS-1:0] prio);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= IN_TDATA_BITS'({prio, id, user});
    do @(posedge clk); while (!s_tready);
    apply_task_op(mode, user, id, prio);
  endtask

  task automatic stop_sending();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: a fresh stall draw after every beat, long hold on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) rx_wait = rx_idle ? $urandom_range(0, 15) : 0;
      if (rx_long_hold > 0) begin
        rx_wait = rx_long_hold;
        rx_long_hold = 0;
      end
      if (rx_wait > 0) begin
        m_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // result check
  always @(posedge clk) begin
    exec_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (exec_expected.size() == 0) begin
        $error("unexpected result beat: found=%0d exec_user=%0h", m_tuser, m_tdata);
        err_count++;
      end else begin
        exp_res = exec_expected.pop_front();
        if (m_tuser !== exp_res.found) begin
          $error("found: expected %0d, actual %0d", exp_res.found, m_tuser);
          err_count++;
        end
        if (m_tdata[USER_BITS-1:0] !== exp_res.user) begin
          $error("exec_user: expected %0h, actual %0h", exp_res.user,
                 m_tdata[USER_BITS-1:0]);
          err_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_op(MODE_EXEC, 16'h0, 10'd0, '0);
    send_op(MODE_ADD, 16'h0, 10'd0, '0);
    send_op(MODE_ADD, USER_MAX, 10'd1023, PRIO_MAX);
    send_op(MODE_EXEC, 16'h0, 10'd0, '0);
    send_op(MODE_EXEC, 16'h0, 10'd0, '0);
    send_op(MODE_EXEC, 16'h0, 10'd0, '0);
    // equal priorities go to the higher task id
    send_op(MODE_ADD, 16'h1111, 10'd5, 30'd7);
    send_op(MODE_ADD, 16'h2222, 10'd9, 30'd7);
    send_op(MODE_EXEC, 16'h0, 10'd0, '0);
    // replace a live task
    send_op(MODE_ADD, 16'h3333, 10'd9, 30'd7);
    send_op(MODE_ADD, 16'h4444, 10'd9, 30'd3);
    send_op(MODE_EDIT, USER_MAX, 10'd5, 30'd1000);
    send_op(MODE_EXEC, 16'h0, 10'd0, '0);
    send_op(MODE_EXEC, 16'h0, 10'd0, '0);
    // edit and remove of absent ids are dropped
    send_op(MODE_EDIT, 16'h0, 10'd12, PRIO_MAX);
    send_op(MODE_REMOVE, 16'h0, 10'd13, '0);
    send_op(MODE_ADD, 16'h5555, 10'd20, 30'd50);
    send_op(MODE_REMOVE, 16'h0, 10'd20, '0);
    send_op(MODE_EXEC, 16'h0, 10'd0, '0);
    send_op(MODE_ADD, 16'h6666, 10'd30, 30'd10);
    send_op(MODE_ADD, 16'h7777, 10'd31, PRIO_MAX - 30'd1);
    send_op(MODE_EDIT, 16'h0, 10'd30, PRIO_MAX);
    send_op(MODE_EXEC, 16'h0, 10'd0, '0);
    send_op(MODE_EXEC, 16'h0, 10'd0, '0);
    send_op(MODE_EXEC, 16'h0, 10'd0, '0);
  endtask

  function automatic logic [ID_BITS-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return ID_BITS'($urandom_range(0, 15));
    if (r < 65) return ID_BITS'($urandom_range(TASK_SLOTS - 16, TASK_SLOTS - 1));
    return ID_BITS'($urandom_range(0, TASK_SLOTS - 1));
  endfunction

  function automatic logic [PRIORITY_BITS-1:0] pick_prio();
    if ($urandom_range(0, 99) < 40) return PRIORITY_BITS'($urandom_range(0, 7));
    return PRIORITY_BITS'($urandom());
  endfunction

  task automatic test_random_mix(int count, int add_pct, int edit_pct, int remove_pct);
    int r;
    logic [MODE_BITS-1:0] mode;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) mode = MODE_ADD;
      else if (r < add_pct + edit_pct) mode = MODE_EDIT;
      else if (r < add_pct + edit_pct + remove_pct) mode = MODE_REMOVE;
      else mode = MODE_EXEC;
      send_op(mode, USER_BITS'($urandom()), pick_id(), pick_prio());
    end
  endtask

  // receiver holds off while execute-top beats keep coming
  task automatic test_output_stall();
    for (int i = 0; i < 10; i++)
      send_op(MODE_ADD, USER_BITS'($urandom()), ID_BITS'(100 + i), pick_prio());
    rx_long_hold = 300;
    for (int i = 0; i < 30; i++)
      send_op(($urandom_range(0, 3) == 0) ? MODE_ADD : MODE_EXEC, USER_BITS'($urandom()),
              ID_BITS'($urandom_range(100, 120)), pick_prio());
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = MODE_ADD;
    for (int i = 0; i < TASK_SLOTS; i++) task_live[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    test_random_mix(200, 40, 20, 15);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    test_random_mix(200, 60, 15, 10);
    test_output_stall();
    tx_idle = 1'b1;
    test_random_mix(200, 20, 15, 15);
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    test_random_mix(200, 40, 20, 15);
    stop_sending();

    while (exec_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0 && exec_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/ptq_pkg.sv
rtl/ptq_ram.sv
rtl/ptq_cell.sv
rtl/ptq_chain.sv
rtl/updatable_priority_task_queue.sv
dv/tb_updatable_priority_task_queue.sv
